/* src/upbt_pkg.sv */
// shared constants, codes and types for the udp port bind table
// no dependencies; used by every module under src
`default_nettype none

package upbt_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // slots are searched in groups: a registered encoder per group, then one across groups
  localparam int GRP_SIZE    = (TABLE_SLOTS < 32) ? TABLE_SLOTS : 32;
  localparam int GRP_W       = (GRP_SIZE > 1) ? $clog2(GRP_SIZE) : 1;
  localparam int NUM_GROUPS  = (TABLE_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_SLOTS   = NUM_GROUPS * GRP_SIZE;

  localparam logic [15:0] EPH_FIRST = 16'd49152;
  localparam logic [15:0] EPH_LAST  = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BIND   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_IN_USE = 2'd1,
    ST_FULL   = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_DEC
  } state_t;

  typedef struct packed {
    logic        en;
    logic        valid;
    logic [15:0] port;
  } cell_wr_t;

  typedef struct packed {
    logic             found;
    logic [GRP_W-1:0] idx;
  } grp_res_t;

endpackage

`default_nettype wire

/* src/upbt_cell.sv */
// one table slot: holds a bound port and its valid bit, flags a match or a free slot
// depends on upbt_pkg
`default_nettype none

module upbt_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmp_en,
  input  wire logic [15:0]       key,
  input  wire upbt_pkg::cell_wr_t wr,
  output logic                   entry_valid,
  output logic                   hit,
  output logic                   free
);

  logic [15:0] entry_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (wr.en) begin
      entry_valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_port <= wr.port;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit  <= entry_valid && (entry_port == key);
      free <= !entry_valid;
    end
  end

endmodule

`default_nettype wire

/* src/upbt_grp_enc.sv */
// registered lowest-set-bit encoder over one group of slot flags
// depends on upbt_pkg
`default_nettype none

module upbt_grp_enc (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [upbt_pkg::GRP_SIZE-1:0] hit_bits,
  input  wire logic [upbt_pkg::GRP_SIZE-1:0] free_bits,
  output upbt_pkg::grp_res_t                 hit_res,
  output upbt_pkg::grp_res_t                 free_res
);

  upbt_pkg::grp_res_t hit_res_next;
  upbt_pkg::grp_res_t free_res_next;

  always_comb begin
    hit_res_next  = '0;
    free_res_next = '0;
    // walk downwards so the lowest set bit wins
    for (int i = upbt_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (hit_bits[i]) begin
        hit_res_next.found = 1'b1;
        hit_res_next.idx   = upbt_pkg::GRP_W'(i);
      end
      if (free_bits[i]) begin
        free_res_next.found = 1'b1;
        free_res_next.idx   = upbt_pkg::GRP_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_res  <= hit_res_next;
      free_res <= free_res_next;
    end
  end

endmodule

`default_nettype wire

/* src/udp_port_bind_table.sv */
// top level of the udp port bind table: request register, row of slot cells,
// group encoders, decision stage and result register; depends on upbt_pkg,
// upbt_cell and upbt_grp_enc
//
// Each request (bind, close or lookup) gives exactly one result. The transfer
// edge registers the request, substituting the ephemeral port for a bind of
// port 0. In the compare state every slot cell compares its port against the
// key in parallel, in the group state the per-group encoders register, and in
// the decision state the lowest matching or free slot is picked, the table
// written and the result loaded. One request is in flight at a time, so a new
// request is taken only once the last has left the decision state. The
// decision stage holds while an earlier result still waits in the output
// register, and a result may wait there while the next request is accepted.
// Binds are refused if the port is already bound (checked first) or the table
// is full; a close of a slot beyond the table is ignored but still answered.
// After reset the table is empty and the ephemeral counter is at 49152.
`default_nettype none

module udp_port_bind_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] port,
  input  wire logic [7:0]  slot,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [7:0]       slot_index,
  output logic [15:0]      bound_port
);

  upbt_pkg::state_t state;
  upbt_pkg::state_t state_next;

  upbt_pkg::op_t q_op;
  logic [15:0]   q_port;
  logic [7:0]    q_slot;
  logic [15:0]   eph_port;
  logic [15:0]   eph_port_next;
  logic [15:0]   key_next;
  logic          accept;
  logic          dec_go;

  logic [upbt_pkg::PAD_SLOTS-1:0]   hit_vec;
  logic [upbt_pkg::PAD_SLOTS-1:0]   free_vec;
  logic [upbt_pkg::TABLE_SLOTS-1:0] valid_vec;

  upbt_pkg::grp_res_t grp_hit  [upbt_pkg::NUM_GROUPS];
  upbt_pkg::grp_res_t grp_free [upbt_pkg::NUM_GROUPS];

  logic                        wr_en;
  logic                        wr_valid;
  logic [15:0]                 wr_port;
  logic [upbt_pkg::SLOT_W-1:0] wr_addr;

  upbt_pkg::status_t res_status;
  logic [7:0]        res_idx;
  logic [15:0]       res_port;

  // request register and ephemeral counter
  assign accept = in_valid && !in_stall;

  always_comb begin
    eph_port_next = eph_port;
    key_next      = port;
    if (upbt_pkg::op_t'(op) == upbt_pkg::OP_BIND && port == 16'd0) begin
      key_next      = eph_port;
      eph_port_next = (eph_port == upbt_pkg::EPH_LAST) ? upbt_pkg::EPH_FIRST
                                                        : eph_port + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eph_port <= upbt_pkg::EPH_FIRST;
    end else if (accept) begin
      eph_port <= eph_port_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op   <= upbt_pkg::op_t'(op);
      q_port <= key_next;
      q_slot <= slot;
    end
  end

  // row of slot cells
  for (genvar i = 0; i < upbt_pkg::TABLE_SLOTS; i++) begin : g_cell
    upbt_pkg::cell_wr_t cell_wr;

    assign cell_wr.en    = wr_en && (wr_addr == upbt_pkg::SLOT_W'(i));
    assign cell_wr.valid = wr_valid;
    assign cell_wr.port  = wr_port;

    upbt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmp_en      (state == upbt_pkg::S_CMP),
      .key         (q_port),
      .wr          (cell_wr),
      .entry_valid (valid_vec[i]),
      .hit         (hit_vec[i]),
      .free        (free_vec[i])
    );
  end

  if (upbt_pkg::PAD_SLOTS > upbt_pkg::TABLE_SLOTS) begin : g_pad
    assign hit_vec[upbt_pkg::PAD_SLOTS-1:upbt_pkg::TABLE_SLOTS]  = '0;
    assign free_vec[upbt_pkg::PAD_SLOTS-1:upbt_pkg::TABLE_SLOTS] = '0;
  end

  // per-group encoders
  for (genvar g = 0; g < upbt_pkg::NUM_GROUPS; g++) begin : g_grp
    upbt_grp_enc u_grp_enc (
      .clk       (clk),
      .en        (state == upbt_pkg::S_GRP),
      .hit_bits  (hit_vec[g*upbt_pkg::GRP_SIZE +: upbt_pkg::GRP_SIZE]),
      .free_bits (free_vec[g*upbt_pkg::GRP_SIZE +: upbt_pkg::GRP_SIZE]),
      .hit_res   (grp_hit[g]),
      .free_res  (grp_free[g])
    );
  end

  // decision: lowest group wins, then the table write and the result
  always_comb begin
    logic                        hit_any;
    logic                        free_any;
    int                          hit_g;
    int                          free_g;
    logic [upbt_pkg::SLOT_W-1:0] hit_slot;
    logic [upbt_pkg::SLOT_W-1:0] free_slot;
    logic                        close_ok;

    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_g    = 0;
    free_g   = 0;
    for (int g = upbt_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g].found) begin
        hit_any = 1'b1;
        hit_g   = g;
      end
      if (grp_free[g].found) begin
        free_any = 1'b1;
        free_g   = g;
      end
    end
    hit_slot  = upbt_pkg::SLOT_W'(hit_g * upbt_pkg::GRP_SIZE + int'(grp_hit[hit_g].idx));
    free_slot = upbt_pkg::SLOT_W'(free_g * upbt_pkg::GRP_SIZE + int'(grp_free[free_g].idx));
    close_ok  = int'(q_slot) < upbt_pkg::TABLE_SLOTS;

    wr_en      = 1'b0;
    wr_valid   = 1'b0;
    wr_port    = 16'd0;
    wr_addr    = '0;
    res_status = upbt_pkg::ST_OK;
    res_idx    = 8'd0;
    res_port   = 16'd0;

    unique case (q_op)
      upbt_pkg::OP_BIND: begin
        res_port = q_port;
        if (hit_any) begin
          res_status = upbt_pkg::ST_IN_USE;
        end else if (free_any) begin
          res_idx  = 8'(free_slot);
          wr_en    = 1'b1;
          wr_valid = 1'b1;
          wr_port  = q_port;
          wr_addr  = free_slot;
        end else begin
          res_status = upbt_pkg::ST_FULL;
        end
      end
      upbt_pkg::OP_CLOSE: begin
        res_idx = q_slot;
        wr_en   = close_ok;
        wr_addr = upbt_pkg::SLOT_W'(q_slot);
      end
      upbt_pkg::OP_LOOKUP: begin
        res_port = q_port;
        if (hit_any) begin
          res_idx = 8'(hit_slot);
        end else begin
          res_status = upbt_pkg::ST_MISS;
        end
      end
      upbt_pkg::OP_NONE: begin
        res_status = upbt_pkg::ST_OK;
      end
      default: begin
        res_status = upbt_pkg::ST_OK;
      end
    endcase

    // only write once the result register can take the transfer
    if (!(state == upbt_pkg::S_DEC && dec_go)) begin
      wr_en = 1'b0;
    end
  end

  assign dec_go = !(out_valid && out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upbt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      upbt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = upbt_pkg::S_CMP;
        end
      end
      upbt_pkg::S_CMP: begin
        state_next = upbt_pkg::S_GRP;
      end
      upbt_pkg::S_GRP: begin
        state_next = upbt_pkg::S_DEC;
      end
      upbt_pkg::S_DEC: begin
        if (dec_go) begin
          state_next = upbt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = upbt_pkg::S_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == upbt_pkg::S_DEC && dec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == upbt_pkg::S_DEC && dec_go) begin
      status     <= res_status;
      slot_index <= res_idx;
      bound_port <= res_port;
    end
  end

  // one request in flight: a transfer is never followed directly by another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request accepted while another is in flight");

  // a result only appears out of the decision stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == upbt_pkg::S_DEC)
    else $error("result loaded outside the decision stage");

  // a successful bind takes exactly one more slot
  a_bind_fills: assert property (@(posedge clk) disable iff (rst)
    (state == upbt_pkg::S_DEC && dec_go && q_op == upbt_pkg::OP_BIND &&
     res_status == upbt_pkg::ST_OK)
    |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("successful bind did not fill one slot");

  // ephemeral counter never leaves its range
  a_eph_range: assert property (@(posedge clk) disable iff (rst)
    eph_port >= upbt_pkg::EPH_FIRST)
    else $error("ephemeral counter out of range");

  // a full table reports no free slot
  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    (state == upbt_pkg::S_DEC && q_op == upbt_pkg::OP_BIND &&
     res_status == upbt_pkg::ST_FULL) |-> free_vec == '0)
    else $error("table full reported with a free slot");

endmodule

`default_nettype wire

/* sim/upbt_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the udp port bind table: keeps its own copy of the bindings,
// works out every result from the request transfers and compares result transfers
// in order; depends on upbt_pkg
module upbt_result_checker
  import upbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] port,
  input  logic [7:0]  slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  slot_index,
  input  logic [15:0] bound_port,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot_index;
    logic [15:0] bound_port;
  } bind_result_t;

  logic [15:0]  held_port [TABLE_SLOTS];
  logic         slot_busy [TABLE_SLOTS];
  logic [15:0]  eph_next;
  bind_result_t awaited_results [$];

  function automatic int first_holder(input logic [15:0] key);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (slot_busy[i] && held_port[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (!slot_busy[i]) return i;
    return -1;
  endfunction

  // updates the shadow table as the block should and returns its answer
  function automatic bind_result_t resolve_request(input op_t code, input logic [15:0] p,
                                                   input logic [7:0] s);
    bind_result_t r;
    logic [15:0]  key;
    int           hit;
    int           spare;
    r.status     = ST_OK;
    r.slot_index = 8'd0;
    r.bound_port = 16'd0;
    key = p;
    case (code)
      OP_BIND: begin
        if (key == 16'd0) begin
          key = eph_next;
          eph_next = (eph_next == EPH_LAST) ? EPH_FIRST : eph_next + 16'd1;
        end
        r.bound_port = key;
        hit   = first_holder(key);
        spare = first_free();
        if (hit >= 0) begin
          r.status = ST_IN_USE;
        end else if (spare < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_busy[spare] = 1'b1;
          held_port[spare] = key;
          r.slot_index = spare[7:0];
        end
      end
      OP_CLOSE: begin
        if (int'(s) < TABLE_SLOTS) begin
          slot_busy[s] = 1'b0;
          held_port[s] = 16'd0;
        end
        r.slot_index = s;
      end
      OP_LOOKUP: begin
        hit = first_holder(key);
        r.bound_port = key;
        if (hit >= 0) r.slot_index = hit[7:0];
        else r.status = ST_MISS;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    bind_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        held_port[i] = 16'd0;
        slot_busy[i] = 1'b0;
      end
      eph_next = EPH_FIRST;
      awaited_results.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      // results leave before the request of this edge can have produced one
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: status %0d slot_index %0d bound_port %0d",
                 status, slot_index, bound_port);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
            fail_count++;
          end
          if (bound_port !== want.bound_port) begin
            $error("bound_port: expected %0d, got %0d", want.bound_port, bound_port);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(resolve_request(op_t'(op), port, slot));
      outstanding <= awaited_results.size();
    end
  end

endmodule

/* sim/udp_port_bind_table_tb.sv */
`timescale 1ns / 100ps
// testbench top for the udp port bind table: clock, reset, request and result
// traffic with random gaps, watchdog and verdict; depends on upbt_pkg,
// udp_port_bind_table and upbt_result_checker
module udp_port_bind_table_tb;
  import upbt_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 200;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  op         = OP_NONE;
  logic [15:0] port       = 16'd0;
  logic [7:0]  slot       = 8'd0;
  logic        out_valid;
  logic        out_stall  = 1'b1;
  logic [1:0]  status;
  logic [7:0]  slot_index;
  logic [15:0] bound_port;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;
  bit hold_req    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  udp_port_bind_table i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .port       (port),
    .slot       (slot),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot_index (slot_index),
    .bound_port (bound_port)
  );

  upbt_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .port        (port),
    .slot        (slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .bound_port  (bound_port),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // request side: optional gap, then hold the request until it is taken
  task automatic send_req(input op_t code, input logic [15:0] p, input logic [7:0] s);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    port     <= p;
    slot     <= s;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(1, 24));
      3:       return 16'($urandom_range(49152, 49200));
      4:       return 16'($urandom_range(65500, 65535));
      default: return 16'($urandom());
    endcase
  endfunction

  // stop offering, let the last transfer reach the count, then wait for every result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: a stall of random length before each transfer, or one long hold-off
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int bind_w  [3];
    int close_w [3];
    int unsigned pick;
    bind_w  = '{25, 55, 35};
    close_w = '{45, 20, 30};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: misses on an empty table, ephemeral binds, clashes, closes, unused op
    send_req(OP_LOOKUP, 16'd0,     8'd0);
    send_req(OP_LOOKUP, 16'hFFFF,  8'hFF);
    send_req(OP_BIND,   16'd0,     8'd0);
    send_req(OP_BIND,   16'd0,     8'd0);
    send_req(OP_BIND,   16'hFFFF,  8'd0);
    send_req(OP_BIND,   16'd1,     8'd0);
    send_req(OP_BIND,   16'hFFFF,  8'd0);
    send_req(OP_BIND,   16'd49154, 8'd0);
    // next ephemeral port is already taken, counter must still move on
    send_req(OP_BIND,   16'd0,     8'd0);
    send_req(OP_LOOKUP, 16'hFFFF,  8'd0);
    send_req(OP_LOOKUP, 16'd49153, 8'd0);
    send_req(OP_CLOSE,  16'd0,     8'd1);
    send_req(OP_LOOKUP, 16'd49153, 8'd0);
    send_req(OP_CLOSE,  16'hFFFF,  8'd1);
    send_req(OP_CLOSE,  16'd0,     8'd255);
    send_req(OP_BIND,   16'h8000,  8'd0);
    send_req(OP_BIND,   16'h7FFF,  8'd0);
    send_req(OP_NONE,   16'hFFFF,  8'hFF);
    send_req(OP_NONE,   16'd0,     8'd0);
    send_req(OP_LOOKUP, 16'd1,     8'd0);
    send_req(OP_CLOSE,  16'd0,     8'd0);
    send_req(OP_LOOKUP, 16'd0,     8'd0);
    send_req(OP_BIND,   16'd1,     8'd0);
    wait_drained();

    // ephemeral sweep without gaps: fills the table, then refused binds still move the counter
    no_gaps = 1'b1;
    repeat (TABLE_SLOTS + 40) send_req(OP_BIND, 16'd0, 8'($urandom()));
    no_gaps = 1'b0;
    wait_drained();
    send_req(OP_BIND, pick_port(), 8'd0);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_gaps = (ph == 1) && (n < 80);
        pick = $urandom_range(0, 99);
        if (pick < bind_w[ph])
          send_req(OP_BIND, ($urandom_range(0, 4) == 0) ? 16'd0 : pick_port(),
                   8'($urandom()));
        else if (pick < bind_w[ph] + close_w[ph])
          send_req(OP_CLOSE, 16'($urandom()),
                   $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 15)));
        else if (pick < 96)
          send_req(OP_LOOKUP, ($urandom_range(0, 19) == 0) ? 16'd0 : pick_port(),
                   8'($urandom()));
        else
          send_req(OP_NONE, 16'($urandom()), 8'($urandom()));
      end
      no_gaps = 1'b0;
      wait_drained();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/upbt_pkg.sv
src/upbt_cell.sv
src/upbt_grp_enc.sv
src/udp_port_bind_table.sv
sim/upbt_result_checker.sv
sim/udp_port_bind_table_tb.sv
